@@ rtl/core/mbsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsp_pkg
// Shared types, constants and the event-length lookup for the MIDI byte
// stream parser.
// ----------------------------------------------------------------------------
package mbsp_pkg;

    localparam int SYSEX_CAPACITY = 8192;
    localparam int SYSEX_CNT_W    = $clog2(SYSEX_CAPACITY + 1);
    localparam logic [SYSEX_CNT_W-1:0] SYSEX_LIMIT = SYSEX_CNT_W'(SYSEX_CAPACITY - 1);

    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    localparam logic [7:0] RT_FIRST = 8'hF8;
    localparam logic [7:0] ST_SYSEX = 8'hF0;
    localparam logic [7:0] ST_EOX   = 8'hF7;

    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        KIND_SHORT = 2'd0,
        KIND_RT    = 2'd1,
        KIND_SYSEX = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [1:0] msg_len;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic       sysex_last;
    } result_t;

    typedef struct packed {
        logic [1:0]          cnt;
        result_t [1:0]       res;
    } rq_push_t;

    typedef struct packed {
        logic [7:0]             running_status;
        logic [1:0]             message_pos;
        logic [1:0]             message_len;
        logic [2:0][7:0]        message_bytes;
        logic [SYSEX_CNT_W-1:0] sysex_count;
    } state_t;

    localparam logic [1:0] SYS_LEN [16] = '{
        2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd0,
        2'd1, 2'd0, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd0
    };

    function automatic logic [1:0] event_length(input logic [7:0] st);
        logic [1:0] len;
        if (!st[7])
            len = 2'd0;
        else if (st < 8'hC0)
            len = 2'd3;
        else if (st < 8'hE0)
            len = 2'd2;
        else if (st < 8'hF0)
            len = 2'd3;
        else
            len = SYS_LEN[st[3:0]];
        return len;
    endfunction

    function automatic result_t mk_result(input kind_t k, input logic [1:0] len,
                                          input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic last);
        result_t r;
        r.kind       = k;
        r.msg_len    = len;
        r.byte0      = b0;
        r.byte1      = b1;
        r.byte2      = b2;
        r.sysex_last = last;
        return r;
    endfunction

endpackage

@@ rtl/core/mbsp_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsp_step
// Next-state and result logic for one input byte or clear request: realtime
// pass, sysex pass and close, status decode and running-status message assembly.
// ----------------------------------------------------------------------------
module mbsp_step
    import mbsp_pkg::*;
(
    input  state_t     st,
    input  logic       req_type,
    input  logic [7:0] data_byte,
    output state_t     st_next,
    output rq_push_t   push
);

    logic [1:0] n;
    logic       cont;
    logic [1:0] pos_inc;

    always_comb
    begin
        st_next = st;
        push    = '0;
        n       = 2'd0;
        cont    = 1'b0;
        pos_inc = 2'd0;
        if (req_type == REQ_CLEAR)
        begin
            st_next.running_status = '0;
            st_next.message_pos    = '0;
            st_next.message_len    = '0;
            st_next.sysex_count    = '0;
        end
        else if (data_byte >= RT_FIRST)
        begin
            push.res[0] = mk_result(KIND_RT, 2'd1, data_byte, 8'd0, 8'd0, 1'b0);
            n = 2'd1;
        end
        else
        begin
            cont = 1'b1;
            if (st.running_status == ST_SYSEX)
            begin
                if (!data_byte[7])
                begin
                    cont = 1'b0;
                    if (st.sysex_count < SYSEX_LIMIT)
                    begin
                        push.res[n[0]] = mk_result(KIND_SYSEX, 2'd1, data_byte,
                                                   8'd0, 8'd0, 1'b0);
                        n = n + 2'd1;
                        st_next.sysex_count = st.sysex_count + 1'b1;
                    end
                end
                else
                begin
                    // close the open transfer before the new status
                    push.res[n[0]] = mk_result(KIND_SYSEX, 2'd1, ST_EOX, 8'd0, 8'd0, 1'b1);
                    n = n + 2'd1;
                    st_next.sysex_count = st.sysex_count + 1'b1;
                end
            end
            if (cont && data_byte[7])
            begin
                st_next.running_status = data_byte;
                st_next.message_pos    = 2'd0;
                st_next.message_len    = event_length(data_byte);
                if (data_byte == ST_SYSEX)
                begin
                    st_next.sysex_count = SYSEX_CNT_W'(1);
                    push.res[n[0]] = mk_result(KIND_SYSEX, 2'd1, ST_SYSEX, 8'd0, 8'd0, 1'b0);
                    n = n + 2'd1;
                end
            end
            if (cont && st_next.message_len != 2'd0 && st_next.message_pos < 2'd3)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (st_next.message_pos == 2'(i))
                        st_next.message_bytes[i] = data_byte;
                end
                pos_inc = st_next.message_pos + 2'd1;
                if (pos_inc >= st_next.message_len)
                begin
                    push.res[n[0]] = mk_result(
                        KIND_SHORT, st_next.message_len, st_next.message_bytes[0],
                        (st_next.message_len > 2'd1) ? st_next.message_bytes[1] : 8'd0,
                        (st_next.message_len > 2'd2) ? st_next.message_bytes[2] : 8'd0,
                        1'b0);
                    n = n + 2'd1;
                    st_next.message_pos = 2'd1;
                end
                else
                begin
                    st_next.message_pos = pos_inc;
                end
            end
        end
        push.cnt = n;
    end

endmodule

@@ rtl/core/mbsp_rq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsp_rq
// Result queue: takes up to two results per cycle, hands out one per
// transfer.
// ----------------------------------------------------------------------------
module mbsp_rq
    import mbsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rq_push_t push,
    input  logic     pop,
    output logic     room,
    output logic     out_vld,
    output result_t  out_res
);

    localparam logic [RQ_CW-1:0] ROOM_MAX = RQ_CW'(RQ_DEPTH - 2);

    result_t            ent_reg [RQ_DEPTH];
    logic [RQ_AW-1:0]   wr_reg;
    logic [RQ_AW-1:0]   wr_next;
    logic [RQ_AW-1:0]   rd_reg;
    logic [RQ_AW-1:0]   rd_next;
    logic [RQ_CW-1:0]   level_reg;
    logic [RQ_CW-1:0]   level_next;

    assign room    = (level_reg <= ROOM_MAX);
    assign out_vld = (level_reg != '0);
    assign out_res = ent_reg[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg + RQ_AW'(push.cnt);
        rd_next    = rd_reg + RQ_AW'(pop);
        level_next = level_reg + RQ_CW'(push.cnt) - RQ_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            ent_reg[wr_reg] <= push.res[0];
        if (push.cnt == 2'd2)
            ent_reg[wr_reg + RQ_AW'(1)] <= push.res[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            level_reg <= level_next;
        end
    end

endmodule

@@ rtl/core/midi_byte_stream_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_core
// MIDI byte stream parser with running status, realtime pass-through and
// sysex pass-through with capacity limit.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle unless the decode stage holds. Each byte
// is registered, decoded combinationally against the parser state, and gives
// zero, one or two results (a status byte that ends sysex gives the closing
// 0xF7 and then any result of its own). Results go through a four-entry queue
// and leave one per output transfer, so the sustained rate is one byte per
// cycle as long as each byte gives at most one result on average and the
// output does not stall; the decode stage holds while the queue has room for
// fewer than two results. Results pass the input register and the queue.
module midi_byte_stream_parser_core
    import mbsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       req_type,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [1:0] msg_len,
    output logic [7:0] byte0,
    output logic [7:0] byte1,
    output logic [7:0] byte2,
    output logic       sysex_last
);

    logic       in_vld_reg;
    logic       req_reg;
    logic [7:0] byte_reg;
    state_t     state_reg;
    state_t     state_next;
    rq_push_t   push_raw;
    rq_push_t   push;
    logic       room;
    logic       fire;
    logic       pop;
    result_t    out_res;

    assign fire     = in_vld_reg && room;
    assign in_ready = !in_vld_reg || fire;
    assign pop      = out_valid && out_ready;

    always_comb
    begin
        push = push_raw;
        if (!fire)
            push.cnt = 2'd0;
    end

    mbsp_step u_step (
        .st        (state_reg),
        .req_type  (req_reg),
        .data_byte (byte_reg),
        .st_next   (state_next),
        .push      (push_raw)
    );

    mbsp_rq u_rq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (pop),
        .room    (room),
        .out_vld (out_valid),
        .out_res (out_res)
    );

    assign kind       = out_res.kind;
    assign msg_len    = out_res.msg_len;
    assign byte0      = out_res.byte0;
    assign byte1      = out_res.byte1;
    assign byte2      = out_res.byte2;
    assign sysex_last = out_res.sysex_last;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg  <= req_type;
            byte_reg <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            state_reg  <= '0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (fire)
                state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_push_max: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (push.cnt != 2'd3))
        else $error("more than two results from one byte");

    a_sysex_data_one: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req_reg == REQ_BYTE && state_reg.running_status == ST_SYSEX
         && !byte_reg[7]) |-> (push.cnt <= 2'd1))
        else $error("sysex data byte gave more than one result");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.message_len != 2'd0) |-> (state_reg.message_pos <= state_reg.message_len))
        else $error("message position beyond message length");

    a_rt_stateless: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req_reg == REQ_BYTE && byte_reg >= RT_FIRST)
        |=> $stable(state_reg))
        else $error("realtime byte changed parser state");
`endif

endmodule
